// ===== design/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg: shared types for the ray/segment intersection unit
// Control and flag groups passed between the front end and the divide units.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Control that travels alongside one coordinate through the divide pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg;
  } rsi_ctrl_t;

  // Flags that come out of a divide unit with its coordinate.
  typedef struct packed {
    logic valid;
    logic hit;
    logic sat;
  } rsi_flags_t;

endpackage

// ===== design/rsi_if.sv =====
// ----------------------------------------------------------------------------
// rsi_in_if / rsi_out_if: channels of the ray/segment intersection unit
// Valid/ready channels carrying one test and one result respectively.
// ----------------------------------------------------------------------------
interface rsi_in_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ray_origin_x;
  logic signed [COORD_WIDTH-1:0] ray_origin_y;
  logic signed [COORD_WIDTH-1:0] ray_toward_x;
  logic signed [COORD_WIDTH-1:0] ray_toward_y;
  logic signed [COORD_WIDTH-1:0] seg_first_x;
  logic signed [COORD_WIDTH-1:0] seg_first_y;
  logic signed [COORD_WIDTH-1:0] seg_second_x;
  logic signed [COORD_WIDTH-1:0] seg_second_y;

  modport source (output valid, ray_origin_x, ray_origin_y, ray_toward_x, ray_toward_y,
                  seg_first_x, seg_first_y, seg_second_x, seg_second_y, input ready);
  modport sink (input valid, ray_origin_x, ray_origin_y, ray_toward_x, ray_toward_y,
                seg_first_x, seg_first_y, seg_second_x, seg_second_y, output ready);
endinterface

interface rsi_out_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;
  logic                          clipped;

  modport source (output valid, hit, hit_x, hit_y, clipped, input ready);
  modport sink (input valid, hit, hit_x, hit_y, clipped, output ready);
endinterface

// ===== design/ray_segment_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// ray_segment_intersection_unit: 2D ray versus segment hit test and hit point
// Determinant tests by sign, hit point through two pipelined dividers.
// ----------------------------------------------------------------------------
// Throughput: one test per cycle; the whole pipeline holds when the result
// register is full and not taken.
// Reset: synchronous active-low rst_n clears every stage valid bit; data
// registers are not reset.
module ray_segment_intersection_unit import rsi_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  rsi_in_if.sink   in_ch,
  rsi_out_if.source out_ch
);

  localparam int W  = COORD_WIDTH;
  localparam int D  = W + 1;
  localparam int PW = 2 * D;
  localparam int NW = PW + 1;
  localparam int H  = (NW + 1) / 2;
  localparam int NUMW = NW + D;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: differences.
  logic                v1_r;
  logic signed [D-1:0] ex1_r, ey1_r, fx1_r, fy1_r, gx1_r, gy1_r, dx1_r, dy1_r;
  logic [W-1:0]        ox1_r, oy1_r;

  function automatic logic signed [D-1:0] sub_d(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    sub_d = $signed({a[W-1], a}) - $signed({b[W-1], b});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex1_r <= sub_d(in_ch.ray_origin_x, in_ch.ray_toward_x);
      ey1_r <= sub_d(in_ch.ray_origin_y, in_ch.ray_toward_y);
      fx1_r <= sub_d(in_ch.seg_first_x, in_ch.seg_second_x);
      fy1_r <= sub_d(in_ch.seg_first_y, in_ch.seg_second_y);
      gx1_r <= sub_d(in_ch.ray_origin_x, in_ch.seg_first_x);
      gy1_r <= sub_d(in_ch.ray_origin_y, in_ch.seg_first_y);
      dx1_r <= sub_d(in_ch.ray_toward_x, in_ch.ray_origin_x);
      dy1_r <= sub_d(in_ch.ray_toward_y, in_ch.ray_origin_y);
      ox1_r <= in_ch.ray_origin_x;
      oy1_r <= in_ch.ray_origin_y;
    end
  end

  // Stage 2: the six cross products and direction magnitudes.
  logic                 v2_r;
  logic signed [PW-1:0] p_ef_r, p_fe_r, p_gf_r, p_fg_r, p_ge_r, p_eg_r;
  logic [D-1:0]         mx2_r, my2_r;
  logic                 nx2_r, ny2_r;
  logic [W-1:0]         ox2_r, oy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ef_r <= ex1_r * fy1_r;
      p_fe_r <= ey1_r * fx1_r;
      p_gf_r <= gx1_r * fy1_r;
      p_fg_r <= gy1_r * fx1_r;
      p_ge_r <= gx1_r * ey1_r;
      p_eg_r <= gy1_r * ex1_r;
      mx2_r  <= dx1_r[D-1] ? D'(-dx1_r) : D'(dx1_r);
      my2_r  <= dy1_r[D-1] ? D'(-dy1_r) : D'(dy1_r);
      nx2_r  <= dx1_r[D-1];
      ny2_r  <= dy1_r[D-1];
      ox2_r  <= ox1_r;
      oy2_r  <= oy1_r;
    end
  end

  // Stage 3: determinant and the two numerators.
  logic                 v3_r;
  logic signed [NW-1:0] det3_r, nt3_r, nu3_r;
  logic [D-1:0]         mx3_r, my3_r;
  logic                 nx3_r, ny3_r;
  logic [W-1:0]         ox3_r, oy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det3_r <= $signed({p_ef_r[PW-1], p_ef_r}) - $signed({p_fe_r[PW-1], p_fe_r});
      nt3_r  <= $signed({p_gf_r[PW-1], p_gf_r}) - $signed({p_fg_r[PW-1], p_fg_r});
      nu3_r  <= $signed({p_ge_r[PW-1], p_ge_r}) - $signed({p_eg_r[PW-1], p_eg_r});
      mx3_r  <= mx2_r;
      my3_r  <= my2_r;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      ox3_r  <= ox2_r;
      oy3_r  <= oy2_r;
    end
  end

  // Stage 4: make the determinant positive, flipping the numerators with it.
  logic                 v4_r, nz4_r;
  logic signed [NW-1:0] det4_r, nt4_r, nu4_r;
  logic [D-1:0]         mx4_r, my4_r;
  logic                 nx4_r, ny4_r;
  logic [W-1:0]         ox4_r, oy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nz4_r  <= (det3_r != '0);
      det4_r <= det3_r[NW-1] ? -det3_r : det3_r;
      nt4_r  <= det3_r[NW-1] ? -nt3_r : nt3_r;
      nu4_r  <= det3_r[NW-1] ? -nu3_r : nu3_r;
      mx4_r  <= mx3_r;
      my4_r  <= my3_r;
      nx4_r  <= nx3_r;
      ny4_r  <= ny3_r;
      ox4_r  <= ox3_r;
      oy4_r  <= oy3_r;
    end
  end

  // Stage 5: hit decision and split products of t numerator by direction.
  logic                v5_r, hit5_r;
  logic [NW-1:0]       det5_r;
  logic [H+D-1:0]      plx5_r, ply5_r;
  logic [NW-H+D-1:0]   phx5_r, phy5_r;
  logic                nx5_r, ny5_r;
  logic [W-1:0]        ox5_r, oy5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit5_r <= nz4_r && !nt4_r[NW-1] && !nu4_r[NW-1] && (nu4_r <= det4_r);
      det5_r <= det4_r;
      plx5_r <= nt4_r[H-1:0] * mx4_r;
      ply5_r <= nt4_r[H-1:0] * my4_r;
      phx5_r <= nt4_r[NW-1:H] * mx4_r;
      phy5_r <= nt4_r[NW-1:H] * my4_r;
      nx5_r  <= nx4_r;
      ny5_r  <= ny4_r;
      ox5_r  <= ox4_r;
      oy5_r  <= oy4_r;
    end
  end

  // Stage 6: recombine the partial products into the dividends.
  rsi_ctrl_t     cx6_r, cy6_r;
  logic [NW-1:0] det6_r;
  logic [NUMW-1:0] numx6_r, numy6_r;
  logic [W-1:0]  ox6_r, oy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx6_r <= '0;
      cy6_r <= '0;
    end else if (en) begin
      cx6_r <= '{valid: v5_r, hit: hit5_r, neg: nx5_r};
      cy6_r <= '{valid: v5_r, hit: hit5_r, neg: ny5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det6_r  <= det5_r;
      numx6_r <= NUMW'(plx5_r) + (NUMW'(phx5_r) << H);
      numy6_r <= NUMW'(ply5_r) + (NUMW'(phy5_r) << H);
      ox6_r   <= ox5_r;
      oy6_r   <= oy5_r;
    end
  end

  rsi_flags_t fx_o, fy_o;

  rsi_coord_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctrl  (cx6_r),
    .num   (numx6_r),
    .den   (det6_r),
    .org   ($signed(ox6_r)),
    .flags (fx_o),
    .coord (out_ch.hit_x)
  );

  rsi_coord_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctrl  (cy6_r),
    .num   (numy6_r),
    .den   (det6_r),
    .org   ($signed(oy6_r)),
    .flags (fy_o),
    .coord (out_ch.hit_y)
  );

  // Both dividers run in lockstep, so either one's valid and hit will do.
  assign out_ch.valid   = fx_o.valid && fy_o.valid;
  assign out_ch.hit     = fx_o.hit;
  assign out_ch.clipped = fx_o.sat || fy_o.sat;

endmodule

// ===== design/rsi_coord_div.sv =====
// ----------------------------------------------------------------------------
// rsi_coord_div: pipelined divide and place of one hit coordinate
// Restoring division, one quotient bit per stage, then sign, offset and
// saturation. Misses leave with the fixed miss coordinate.
// ----------------------------------------------------------------------------
module rsi_coord_div import rsi_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  rsi_ctrl_t                     ctrl,
  input  logic [3*COORD_WIDTH+3:0]      num,
  input  logic [2*COORD_WIDTH+2:0]      den,
  input  logic signed [COORD_WIDTH-1:0] org,
  output rsi_flags_t                    flags,
  output logic signed [COORD_WIDTH-1:0] coord
);

  localparam int QW   = COORD_WIDTH + 1;
  localparam int NW   = 2 * COORD_WIDTH + 3;
  localparam int NUMW = NW + QW;
  localparam int SW   = COORD_WIDTH + 3;
  localparam logic [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] MISS_C = (FRAC_BITS > COORD_WIDTH - 1) ? MIN_C :
      COORD_WIDTH'(-(longint'(1) << FRAC_BITS));

  logic [NW-1:0]          rem_r  [QW+1];
  logic [QW-1:0]          lo_r   [QW+1];
  logic [QW-1:0]          quo_r  [QW+1];
  logic [NW-1:0]          den_r  [QW+1];
  logic [COORD_WIDTH-1:0] org_r  [QW+1];
  rsi_ctrl_t              ctrl_r [QW+1];
  logic                   ov_r   [QW+1];

  logic signed [SW-1:0]   sum_r;
  rsi_ctrl_t              fctrl_r;
  logic                   fov_r;
  rsi_flags_t             flags_r;
  logic [COORD_WIDTH-1:0] coord_r;

  // Entry stage: quotients of more than QW bits saturate, otherwise the upper
  // numerator bits already form a remainder below the divisor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r[0] <= '0;
    end else if (en) begin
      ctrl_r[0] <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[NUMW-1:QW];
      lo_r[0]  <= num[QW-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      org_r[0] <= org;
      ov_r[0]  <= (num[NUMW-1:QW] >= den);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;

    assign trial = {rem_r[k], lo_r[k][QW-1]};
    assign ge    = (trial >= {1'b0, den_r[k]});
    assign diff  = trial - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctrl_r[k+1] <= '0;
      end else if (en) begin
        ctrl_r[k+1] <= ctrl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[NW-1:0] : trial[NW-1:0];
        lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][QW-2:0], ge};
        den_r[k+1] <= den_r[k];
        org_r[k+1] <= org_r[k];
        ov_r[k+1]  <= ov_r[k];
      end
    end
  end

  logic signed [SW-1:0] q_signed;
  assign q_signed = ctrl_r[QW].neg ? -$signed({2'b00, quo_r[QW]}) : $signed({2'b00, quo_r[QW]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fctrl_r <= '0;
      flags_r <= '0;
    end else if (en) begin
      fctrl_r       <= ctrl_r[QW];
      flags_r.valid <= fctrl_r.valid;
      flags_r.hit   <= fctrl_r.hit;
      flags_r.sat   <= fctrl_r.hit && (fov_r || (sum_r > $signed({{4{1'b0}}, MAX_C[COORD_WIDTH-2:0]}))
                       || (sum_r < $signed({{4{1'b1}}, MIN_C[COORD_WIDTH-2:0]})));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= $signed({{3{org_r[QW][COORD_WIDTH-1]}}, org_r[QW]}) + q_signed;
      fov_r <= ov_r[QW];
      if (!fctrl_r.hit) begin
        coord_r <= MISS_C;
      end else if (fov_r) begin
        coord_r <= fctrl_r.neg ? MIN_C : MAX_C;
      end else if (sum_r > $signed({{4{1'b0}}, MAX_C[COORD_WIDTH-2:0]})) begin
        coord_r <= MAX_C;
      end else if (sum_r < $signed({{4{1'b1}}, MIN_C[COORD_WIDTH-2:0]})) begin
        coord_r <= MIN_C;
      end else begin
        coord_r <= sum_r[COORD_WIDTH-1:0];
      end
    end
  end

  assign flags = flags_r;
  assign coord = $signed(coord_r);

endmodule
